### design/kgd_pkg.sv
// Shared types, gesture codes, register indexes and the per-key step function.
`default_nettype none
package kgd_pkg;

   localparam logic [2:0] GS_INITIAL = 3'd0;
   localparam logic [2:0] GS_PRESS   = 3'd1;
   localparam logic [2:0] GS_CLICK   = 3'd2;
   localparam logic [2:0] GS_DPRESS  = 3'd3;
   localparam logic [2:0] GS_DCLICK  = 3'd4;
   localparam logic [2:0] GS_LPRESS  = 3'd5;
   localparam logic [2:0] GS_LCLICK  = 3'd6;

   localparam logic [1:0] OP_LEVEL = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;
   localparam logic [1:0] OP_TIMED = 2'd3;

   localparam logic [1:0] CSR_LONG_PRESS = 2'd0;
   localparam logic [1:0] CSR_DOUBLE_WIN = 2'd1;
   localparam logic [1:0] CSR_BLOCKED    = 2'd2;

   typedef struct packed {
      logic        level;
      logic [2:0]  gesture;
      logic [31:0] state_timer;
      logic [31:0] event_timer;
   } kgd_rec_type;

   localparam int REC_WIDTH = $bits(kgd_rec_type);

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } kgd_div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] remainder;
   } kgd_div_rsp_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic kgd_rec_type advance(input kgd_rec_type rec, input logic [31:0] dt,
                                           input logic [31:0] lpt, input logic [31:0] dpw);
      kgd_rec_type r;
      logic [31:0] st;
      logic [2:0]  g;
      st = sat_add(rec.state_timer, dt);
      g = rec.gesture;
      r = rec;
      r.event_timer = sat_add(rec.event_timer, dt);
      case (g)
         GS_PRESS, GS_DPRESS: begin
            if (rec.level && st >= lpt) begin
               g = GS_LPRESS;
               st = '0;
            end else if (!rec.level) begin
               g = (g == GS_PRESS) ? GS_CLICK : GS_DCLICK;
               st = '0;
            end
         end
         GS_CLICK: begin
            if (rec.level && st < dpw) begin
               g = GS_DPRESS;
               st = '0;
            end else if (st >= dpw) begin
               g = GS_INITIAL;
               st = '0;
            end
         end
         GS_DCLICK, GS_LCLICK: begin
            if (st != '0) begin
               g = GS_INITIAL;
               st = '0;
            end
         end
         GS_LPRESS: begin
            if (!rec.level) begin
               g = GS_LCLICK;
               st = '0;
            end
         end
         default: begin
            if (rec.level) begin
               g = GS_PRESS;
               st = '0;
            end else begin
               g = GS_INITIAL;
            end
         end
      endcase
      r.gesture = g;
      r.state_timer = st;
      return r;
   endfunction

endpackage
`default_nettype wire

### design/kgd_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module kgd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### design/kgd_div.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
`default_nettype none
module kgd_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire kgd_pkg::kgd_div_req_type div_req,
   output      kgd_pkg::kgd_div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [32:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dsr_in = dsr_ff;
      trial = {rem_ff, dvd_ff[31]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         dvd_in = div_req.dividend;
         dsr_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, dsr_ff}) ? 32'(trial - {1'b0, dsr_ff}) : trial[31:0];
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
`default_nettype wire

### design/key_gesture_detector.sv
// Top level: key gesture detector with per-key record RAM and a sequencer.
//
// Request words (req_valid / req_stall) carry one operation each: key level,
// tick, check query or timed check query. Every word yields exactly one
// response word (rsp_valid / rsp_stall) with matched and key_state.
// Configuration registers are written through csr_valid / csr_ready with
// csr_index and csr_data; csr_ready is always high.
// Steps: key level and check query pass from accept through S_EXEC and S_FIN
// to the response; a timed check query that passes its checks also waits in
// S_DIV for the bit-serial remainder unit; a tick walks the record RAM one key
// per cycle; a word with a key out of range goes straight to S_FIN.
// req_stall falls in the same cycle as rsp_valid is set for the response.
// Key records live in one RAM with one read and one write port.
// After reset the block clears every key of the record RAM with
// req_stall high. The block takes a new word only once the previous one has
// finished; a finished response waits in the output register while the
// receiver stalls, and the next word may be taken meanwhile.
`default_nettype none
module key_gesture_detector #(
   parameter int NUM_KEYS = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [8:0]  req_key_index,
   input  wire logic        req_key_pressed,
   input  wire logic [31:0] req_elapsed_time,
   input  wire logic [6:0]  req_state_mask,
   input  wire logic [31:0] req_wait_time,
   input  wire logic [31:0] req_repeat_period,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_matched,
   output      logic [2:0]  rsp_key_state,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int AW = $clog2(NUM_KEYS);
   localparam logic [AW-1:0] LAST_KEY = AW'(NUM_KEYS - 1);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_EXEC  = 6'b000100,
      S_TICK  = 6'b001000,
      S_DIV   = 6'b010000,
      S_FIN   = 6'b100000
   } kgd_state_type;

   kgd_state_type state_ff, state_in;

   logic [31:0]   lpt_ff, dpw_ff;
   logic          blocked_ff;
   logic [31:0]   last_tick_ff, last_tick_in;

   logic [1:0]    op_ff, op_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          lvl_ff, lvl_in;
   logic [6:0]    mask_ff, mask_in;
   logic [31:0]   wait_ff, wait_in;
   logic [31:0]   period_ff, period_in;

   logic [AW-1:0] cnt_ff, cnt_in;
   logic          issue_ff, issue_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;

   logic          res_matched_ff, res_matched_in;
   logic [2:0]    res_state_ff, res_state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_matched_ff, rsp_matched_in;
   logic [2:0]    rsp_key_state_ff, rsp_key_state_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   kgd_pkg::kgd_rec_type wr_data, rd_data;

   kgd_pkg::kgd_div_req_type div_req;
   kgd_pkg::kgd_div_rsp_type div_rsp;

   logic [31:0]   key_ext;
   logic          key_in_range;
   logic          accept;
   logic [2:0]    g_eff;
   logic          ok;

   kgd_ram #(
      .WIDTH(kgd_pkg::REC_WIDTH),
      .DEPTH(NUM_KEYS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   kgd_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign key_ext = {23'd0, req_key_index};
   assign key_in_range = key_ext < 32'(NUM_KEYS);
   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      g_eff = rd_data.gesture;
      if (g_eff == kgd_pkg::GS_CLICK && rd_data.state_timer != '0) begin
         g_eff = kgd_pkg::GS_INITIAL;
      end
      if (g_eff > kgd_pkg::GS_LCLICK) begin
         g_eff = kgd_pkg::GS_INITIAL;
      end
      ok = !blocked_ff && mask_ff[g_eff];
   end

   always_comb begin
      state_in = state_ff;
      last_tick_in = last_tick_ff;
      op_in = op_ff;
      addr_in = addr_ff;
      lvl_in = lvl_ff;
      mask_in = mask_ff;
      wait_in = wait_ff;
      period_in = period_ff;
      cnt_in = cnt_ff;
      issue_in = issue_ff;
      pend_in = 1'b0;
      pend_addr_in = pend_addr_ff;
      res_matched_in = res_matched_ff;
      res_state_in = res_state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_matched_in = rsp_matched_ff;
      rsp_key_state_in = rsp_key_state_ff;
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = rd_data;
      rd_addr = key_ext[AW-1:0];
      div_req.start = 1'b0;
      div_req.dividend = rd_data.event_timer;
      div_req.divisor = period_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = cnt_ff;
            wr_data = '0;
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == LAST_KEY) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in = req_opcode;
               addr_in = key_ext[AW-1:0];
               lvl_in = req_key_pressed;
               mask_in = req_state_mask;
               wait_in = req_wait_time;
               period_in = req_repeat_period;
               res_matched_in = 1'b0;
               res_state_in = kgd_pkg::GS_INITIAL;
               if (req_opcode == kgd_pkg::OP_TICK) begin
                  last_tick_in = req_elapsed_time;
                  cnt_in = '0;
                  issue_in = 1'b1;
                  state_in = S_TICK;
               end else if (key_in_range) begin
                  state_in = S_EXEC;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
            case (op_ff)
               kgd_pkg::OP_LEVEL: begin
                  if (rd_data.level != lvl_ff) begin
                     wr_en = 1'b1;
                     wr_data.level = lvl_ff;
                     wr_data.event_timer = '0;
                  end
               end
               kgd_pkg::OP_CHECK: begin
                  res_state_in = g_eff;
                  res_matched_in = ok;
               end
               kgd_pkg::OP_TIMED: begin
                  res_state_in = g_eff;
                  if (ok && period_ff != '0 && rd_data.event_timer >= wait_ff) begin
                     div_req.start = 1'b1;
                     state_in = S_DIV;
                  end
               end
               default: begin
               end
            endcase
         end
         S_TICK: begin
            rd_addr = cnt_ff;
            if (issue_ff) begin
               pend_in = 1'b1;
               pend_addr_in = cnt_ff;
               cnt_in = cnt_ff + AW'(1);
               if (cnt_ff == LAST_KEY) begin
                  issue_in = 1'b0;
               end
            end
            if (pend_ff) begin
               wr_en = 1'b1;
               wr_addr = pend_addr_ff;
               wr_data = kgd_pkg::advance(rd_data, last_tick_ff, lpt_ff, dpw_ff);
            end
            if (!issue_ff && !pend_ff) begin
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               res_matched_in = div_rsp.remainder < last_tick_ff;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_matched_in = res_matched_ff;
               rsp_key_state_in = res_state_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         issue_ff <= 1'b0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_tick_ff <= '0;
         lpt_ff <= 32'd500;
         dpw_ff <= 32'd300;
         blocked_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         issue_ff <= issue_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         last_tick_ff <= last_tick_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               kgd_pkg::CSR_LONG_PRESS: lpt_ff <= csr_data;
               kgd_pkg::CSR_DOUBLE_WIN: dpw_ff <= csr_data;
               kgd_pkg::CSR_BLOCKED:    blocked_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
      op_ff <= op_in;
      addr_ff <= addr_in;
      lvl_ff <= lvl_in;
      mask_ff <= mask_in;
      wait_ff <= wait_in;
      period_ff <= period_in;
      pend_addr_ff <= pend_addr_in;
      res_matched_ff <= res_matched_in;
      res_state_ff <= res_state_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_key_state_ff <= rsp_key_state_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;
   assign rsp_key_state = rsp_key_state_ff;

`ifndef SYNTHESIS
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_key_state <= kgd_pkg::GS_LCLICK)
      else $error("key state out of range");
   a_blocked_false: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_matched |-> !blocked_ff)
      else $error("match reported while input blocked");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV)
      else $error("remainder done outside wait state");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !wr_en)
      else $error("record write while idle");
`endif

endmodule
`default_nettype wire
